/* hdl/tgsb_pkg.sv */
// ----------------------------------------------------------------------------
// tgsb_pkg: shared types and constants
// Item layouts, mode codes, status codes and sizing defaults of the grid buffer.
// ----------------------------------------------------------------------------
package tgsb_pkg;

	localparam int DEF_NUM_GRIDS = 8;
	localparam int DEF_MAX_ROWS  = 64;
	localparam int DEF_MAX_COLS  = 256;

	localparam int GLYPH_W = 21;
	localparam int HL_W    = 16;
	localparam int CELL_W  = GLYPH_W + HL_W;

	localparam logic [2:0] MODE_LINE    = 3'd0;
	localparam logic [2:0] MODE_RESIZE  = 3'd1;
	localparam logic [2:0] MODE_CLEAR   = 3'd2;
	localparam logic [2:0] MODE_SCROLL  = 3'd3;
	localparam logic [2:0] MODE_CURSOR  = 3'd4;
	localparam logic [2:0] MODE_DESTROY = 3'd5;
	localparam logic [2:0] MODE_READ    = 3'd6;

	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_ABSENT = 2'd1;
	localparam logic [1:0] ST_REJECT = 2'd2;

	localparam logic [GLYPH_W-1:0] BLANK_GLYPH = GLYPH_W'(32'h20);

	typedef struct packed {
		logic [2:0]         mode;
		logic [2:0]         grid_id;
		logic signed [15:0] row_or_top;
		logic signed [15:0] bottom;
		logic signed [15:0] col_or_left;
		logic signed [15:0] right;
		logic signed [15:0] count;
		logic [20:0]        glyph;
		logic [15:0]        highlight;
		logic               highlight_given;
		logic               run_start;
	} in_item_t;

	typedef struct packed {
		logic [1:0]         status;
		logic [20:0]        cell_glyph;
		logic [15:0]        cell_highlight;
		logic [2:0]         cursor_slot;
		logic signed [15:0] cursor_row_out;
		logic signed [15:0] cursor_col_out;
	} out_item_t;

	// cell-walk command passed from the front to the back
	localparam logic [1:0] OP_NONE   = 2'd0;
	localparam logic [1:0] OP_FILL   = 2'd1; // write data over rect, skip keep rect
	localparam logic [1:0] OP_COPY   = 2'd2; // row copy for scroll
	localparam logic [1:0] OP_READ   = 2'd3;

	typedef struct packed {
		logic [1:0]         op;
		logic [5:0]         grid;
		logic signed [17:0] r0;       // first row
		logic signed [17:0] r_end;    // stop when row reaches this
		logic               r_down;   // walk rows downward
		logic signed [17:0] roff;     // source row offset for copy
		logic [10:0]        c0;
		logic [10:0]        c_end;
		logic [8:0]         keep_h;   // fill skips r<keep_h && c<keep_w
		logic [10:0]        keep_w;
		logic [CELL_W-1:0]  data;     // fill/run data
		out_item_t          res;      // result with read fields pending
	} cmd_t;

endpackage

/* hdl/tgsb_ram.sv */
// ----------------------------------------------------------------------------
// tgsb_ram: generic single-port RAM
// One write or one read per cycle, registered read data.
// ----------------------------------------------------------------------------
module tgsb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end
endmodule

/* hdl/tgsb_front.sv */
// ----------------------------------------------------------------------------
// tgsb_front: item decoder and grid table
// Keeps per-grid size, cursor and the open line, and turns each item into a
// cell-walk command for the back end.
// ----------------------------------------------------------------------------
module tgsb_front
	import tgsb_pkg::*;
#(
	parameter int NUM_GRIDS = DEF_NUM_GRIDS,
	parameter int MAX_ROWS  = DEF_MAX_ROWS,
	parameter int MAX_COLS  = DEF_MAX_COLS
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  in_item_t in_item,
	output logic     cmd_valid,
	input  logic     cmd_ready,
	output cmd_t     cmd
);
	localparam int GW  = 6;
	localparam int GIX = (NUM_GRIDS > 1) ? $clog2(NUM_GRIDS) : 1;

	logic               present_q [NUM_GRIDS];
	logic [10:0]        width_q   [NUM_GRIDS];
	logic [8:0]         height_q  [NUM_GRIDS];
	logic signed [15:0] crow_q    [NUM_GRIDS];
	logic signed [15:0] ccol_q    [NUM_GRIDS];
	logic [2:0]         cursor_q;
	logic               run_valid_q;
	logic [2:0]         run_grid_q;
	logic [8:0]         run_row_q;
	logic [16:0]        run_col_q;
	logic [15:0]        run_hl_q;

	logic               ok, pres;
	logic [10:0]        w;
	logic [8:0]         h;
	logic signed [17:0] row, col, bot, rgt, cnt;
	logic               accept;

	// next-state and command
	logic               n_present, n_run_valid;
	logic [10:0]        n_width, hs_w;
	logic [8:0]         n_height;
	logic signed [15:0] n_crow, n_ccol;
	logic [2:0]         n_cursor;
	logic               wr_grid, n_run_load;
	logic [2:0]         rg;
	logic [8:0]         rrow;
	logic [16:0]        rcol, rend;
	logic [15:0]        hl;
	cmd_t               c;
	logic signed [17:0] top_c, bot_c, left_c, rgt_c;
	logic [2:0]         cs;
	logic               cpres;

	assign in_ready = ~cmd_valid | cmd_ready;
	assign accept   = in_valid & in_ready;

	function automatic logic signed [17:0] clamp(input logic signed [17:0] v,
		input logic signed [17:0] hi);
		clamp = (v < 0) ? 18'sd0 : ((v > hi) ? hi : v);
	endfunction

	// table index of a grid slot
	function automatic logic [GIX-1:0] gidx(input logic [2:0] g);
		gidx = GIX'(g);
	endfunction

	always_comb begin
		ok   = 32'(in_item.grid_id) < NUM_GRIDS;
		pres = ok & present_q[gidx(in_item.grid_id)];
		w    = ok ? width_q[gidx(in_item.grid_id)] : '0;
		h    = ok ? height_q[gidx(in_item.grid_id)] : '0;
		row  = 18'(in_item.row_or_top);
		col  = 18'(in_item.col_or_left);
		bot  = 18'(in_item.bottom);
		rgt  = 18'(in_item.right);
		cnt  = 18'(in_item.count);

		n_present = pres; n_width = w; n_height = h;
		n_crow = ok ? crow_q[gidx(in_item.grid_id)] : '0;
		n_ccol = ok ? ccol_q[gidx(in_item.grid_id)] : '0;
		n_cursor = cursor_q;
		wr_grid = 1'b0;
		n_run_valid = run_valid_q;
		n_run_load = 1'b0;
		rg = run_grid_q; rrow = run_row_q; rcol = run_col_q; hl = run_hl_q;
		rend = run_col_q;
		hs_w = '0;
		top_c = '0; bot_c = '0; left_c = '0; rgt_c = '0;

		c = '0;
		c.op = OP_NONE;
		c.grid = GW'(in_item.grid_id);
		c.res.status = ST_OK;

		case (in_item.mode)
			MODE_LINE: begin
				if (in_item.run_start) begin
					n_run_valid = 1'b0;
					if (!pres) begin
						c.res.status = ST_ABSENT;
					end else if (row < 0 || row >= 18'(h) || col < 0) begin
						c.res.status = ST_REJECT;
					end else begin
						n_run_valid = 1'b1;
						rg = in_item.grid_id; rrow = row[8:0]; rcol = col[16:0]; hl = '0;
					end
				end else if (!run_valid_q) begin
					c.res.status = ST_REJECT;
				end else if (32'(run_grid_q) >= NUM_GRIDS ||
					!present_q[gidx(run_grid_q)]) begin
					n_run_valid = 1'b0;
					c.res.status = ST_ABSENT;
				end else if (run_row_q >= height_q[gidx(run_grid_q)]) begin
					n_run_valid = 1'b0;
					c.res.status = ST_REJECT;
				end
				if (n_run_valid) begin
					n_run_load = 1'b1;
					if (in_item.highlight_given) hl = in_item.highlight;
					hs_w = width_q[gidx(rg)];
					rend = rcol;
					if (cnt > 0 && 18'(rcol) < 18'(hs_w)) begin
						rend = (18'(rcol) + cnt > 18'(hs_w)) ? 17'(hs_w) : 17'(rcol + cnt[16:0]);
						c.op = OP_FILL;
						c.grid = GW'(rg);
						c.r0 = 18'(rrow); c.r_end = 18'(rrow) + 18'sd1;
						c.c0 = 11'(rcol); c.c_end = 11'(rend);
						c.data = {hl, in_item.glyph};
					end
				end else begin
					n_run_load = 1'b1;
				end
			end
			MODE_RESIZE: begin
				if (!ok) begin
					c.res.status = ST_ABSENT;
				end else begin
					if (!pres) begin w = '0; h = '0; end
					wr_grid = 1'b1;
					n_present = 1'b1;
					n_width  = 11'(clamp(col, 18'(MAX_COLS)));
					n_height = 9'(clamp(row, 18'(MAX_ROWS)));
					c.op = OP_FILL;
					c.r0 = '0; c.r_end = 18'(n_height);
					c.c0 = '0; c.c_end = n_width;
					c.keep_h = h; c.keep_w = w;
					c.data = {16'd0, BLANK_GLYPH};
				end
			end
			MODE_CLEAR: begin
				if (!pres) c.res.status = ST_ABSENT;
				else begin
					c.op = OP_FILL;
					c.r0 = '0; c.r_end = 18'(h);
					c.c0 = '0; c.c_end = w;
					c.data = {16'd0, BLANK_GLYPH};
				end
			end
			MODE_SCROLL: begin
				if (!pres) c.res.status = ST_ABSENT;
				else begin
					top_c = clamp(row, 18'(h)); bot_c = clamp(bot, 18'(h));
					left_c = clamp(col, 18'(w)); rgt_c = clamp(rgt, 18'(w));
					c.c0 = 11'(left_c); c.c_end = 11'(rgt_c); c.roff = cnt;
					if (cnt > 0 && top_c < bot_c - cnt && left_c < rgt_c) begin
						c.op = OP_COPY; c.r0 = top_c; c.r_end = bot_c - cnt;
					end else if (cnt < 0 && bot_c - 18'sd1 >= top_c - cnt && left_c < rgt_c) begin
						c.op = OP_COPY; c.r_down = 1'b1;
						c.r0 = bot_c - 18'sd1; c.r_end = top_c - cnt - 18'sd1;
					end
				end
			end
			MODE_CURSOR: begin
				if (!ok) c.res.status = ST_ABSENT;
				else begin
					wr_grid = 1'b1; n_present = 1'b1;
					if (!pres) begin n_width = '0; n_height = '0; end
					n_crow = in_item.row_or_top; n_ccol = in_item.col_or_left;
					n_cursor = in_item.grid_id;
				end
			end
			MODE_DESTROY: begin
				if (!pres) c.res.status = ST_ABSENT;
				else begin
					wr_grid = 1'b1; n_present = 1'b0;
					n_width = '0; n_height = '0; n_crow = '0; n_ccol = '0;
					if (run_grid_q == in_item.grid_id) n_run_valid = 1'b0;
				end
			end
			MODE_READ: begin
				if (!pres) c.res.status = ST_ABSENT;
				else if (row < 0 || row >= 18'(h) || col < 0 || col >= 18'(w))
					c.res.status = ST_REJECT;
				else begin
					c.op = OP_READ; c.r0 = row; c.c0 = 11'(col);
				end
			end
			default: ;
		endcase

		// cursor fields after this item
		cs = n_cursor;
		cpres = (32'(cs) < NUM_GRIDS) &&
			((wr_grid && cs == in_item.grid_id) ? n_present : present_q[gidx(cs)]);
		c.res.cursor_slot = cs;
		if (!cpres) begin
			c.res.cursor_row_out = '0; c.res.cursor_col_out = '0;
		end else if (wr_grid && cs == in_item.grid_id) begin
			c.res.cursor_row_out = n_crow; c.res.cursor_col_out = n_ccol;
		end else begin
			c.res.cursor_row_out = crow_q[gidx(cs)];
			c.res.cursor_col_out = ccol_q[gidx(cs)];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_GRIDS; i++) begin
				present_q[i] <= 1'b0; width_q[i] <= '0; height_q[i] <= '0;
				crow_q[i] <= '0; ccol_q[i] <= '0;
			end
			cursor_q <= '0; run_valid_q <= 1'b0; run_grid_q <= '0;
			run_row_q <= '0; run_col_q <= '0; run_hl_q <= '0;
			cmd_valid <= 1'b0;
		end else begin
			cmd_valid <= accept | (cmd_valid & ~cmd_ready);
			if (accept) begin
				cursor_q <= n_cursor;
				run_valid_q <= n_run_valid;
				if (n_run_load && n_run_valid) begin
					run_grid_q <= rg; run_row_q <= rrow; run_col_q <= rend; run_hl_q <= hl;
				end
				if (wr_grid) begin
					present_q[gidx(in_item.grid_id)] <= n_present;
					width_q[gidx(in_item.grid_id)]   <= n_width;
					height_q[gidx(in_item.grid_id)]  <= n_height;
					crow_q[gidx(in_item.grid_id)]    <= n_crow;
					ccol_q[gidx(in_item.grid_id)]    <= n_ccol;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) cmd <= c;
	end
endmodule

/* hdl/tgsb_back.sv */
// ----------------------------------------------------------------------------
// tgsb_back: cell walker
// Carries out fill, copy and read commands on the cell memory, then issues
// the result item.
// ----------------------------------------------------------------------------
module tgsb_back
	import tgsb_pkg::*;
#(
	parameter int NUM_GRIDS = DEF_NUM_GRIDS,
	parameter int MAX_ROWS  = DEF_MAX_ROWS,
	parameter int MAX_COLS  = DEF_MAX_COLS
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cmd_valid,
	output logic      cmd_ready,
	input  cmd_t      cmd,
	output logic      out_valid,
	input  logic      out_ready,
	output out_item_t out_item
);
	localparam int RW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int CW    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
	localparam int GWD   = (NUM_GRIDS > 1) ? $clog2(NUM_GRIDS) : 1;
	localparam int DEPTH = NUM_GRIDS * (1 << RW) * (1 << CW);
	localparam int AW    = $clog2(DEPTH);

	localparam logic [2:0] S_IDLE = 3'd0, S_FILL = 3'd1, S_CRD = 3'd2,
		S_CWR = 3'd3, S_RD = 3'd4, S_RDW = 3'd5, S_OUT = 3'd6;

	logic [2:0]         state_q;
	cmd_t               c_q;
	logic signed [17:0] row_q;
	logic [10:0]        col_q;
	logic               we;
	logic [AW-1:0]      addr;
	logic [CELL_W-1:0]  wdata, rdata;
	logic signed [17:0] arow;
	logic               row_last, col_last, skip;
	logic               issue;

	function automatic logic [AW-1:0] cell_addr(input logic [5:0] g,
		input logic signed [17:0] r, input logic [10:0] col);
		cell_addr = AW'({g[GWD-1:0], r[RW-1:0], col[CW-1:0]});
	endfunction

	tgsb_ram #(.WIDTH(CELL_W), .DEPTH(DEPTH)) u_ram (
		.clk, .we, .addr, .wdata, .rdata
	);

	// a waiting result only holds the walker in S_OUT
	assign cmd_ready = (state_q == S_IDLE);
	assign issue     = (state_q == S_OUT) & (~out_valid | out_ready);
	assign col_last  = (col_q + 11'd1 >= c_q.c_end);
	assign row_last  = c_q.r_down ? (row_q - 18'sd1 == c_q.r_end)
	                              : (row_q + 18'sd1 == c_q.r_end);
	assign skip      = (row_q < 18'(c_q.keep_h)) && (col_q < c_q.keep_w);

	always_comb begin
		we = 1'b0; wdata = c_q.data; arow = row_q;
		case (state_q)
			S_FILL: we = ~skip;
			S_CRD:  arow = row_q + c_q.roff;
			S_CWR:  begin we = 1'b1; wdata = rdata; end
			default: ;
		endcase
		addr = cell_addr(c_q.grid, arow, col_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE; out_valid <= 1'b0;
		end else begin
			out_valid <= issue | (out_valid & ~out_ready);
			case (state_q)
				S_IDLE: if (cmd_valid && cmd_ready) begin
					case (cmd.op)
						OP_FILL: state_q <= (cmd.r0 < cmd.r_end && cmd.c0 < cmd.c_end)
							? S_FILL : S_OUT;
						OP_COPY: state_q <= S_CRD;
						OP_READ: state_q <= S_RD;
						default: state_q <= S_OUT;
					endcase
				end
				S_FILL: if (col_last) begin
					if (row_last) state_q <= S_OUT;
				end
				S_CRD: state_q <= S_CWR;
				S_CWR: state_q <= (col_last && row_last) ? S_OUT : S_CRD;
				S_RD:  state_q <= S_RDW;
				S_RDW: state_q <= S_OUT;
				S_OUT: if (issue) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: if (cmd_valid && cmd_ready) begin
				c_q <= cmd; row_q <= cmd.r0; col_q <= cmd.c0;
			end
			S_FILL, S_CWR: if (col_last) begin
				col_q <= c_q.c0;
				row_q <= c_q.r_down ? row_q - 18'sd1 : row_q + 18'sd1;
			end else begin
				col_q <= col_q + 11'd1;
			end
			S_RDW: begin
				c_q.res.cell_glyph <= rdata[GLYPH_W-1:0];
				c_q.res.cell_highlight <= rdata[CELL_W-1:GLYPH_W];
			end
			S_OUT: if (issue) out_item <= c_q.res;
			default: ;
		endcase
	end
endmodule

/* hdl/text_grid_screen_buffer.sv */
// Each item is decoded into the command register, then carried out by the walker;
// fills write cells one by one, and scrolls read then write each copied cell.
// The walker takes a new command only when idle, once its last result has been issued.
// A one-entry command register parts front and back; a waiting result holds the walker.
// Reset: arst_n clears grid table, cursor, open line and handshakes; cells stay.
// ----------------------------------------------------------------------------
// text_grid_screen_buffer: character grid store with scroll region
// Top level joining the item decoder, the cell walker and the cell memory.
// ----------------------------------------------------------------------------
module text_grid_screen_buffer
	import tgsb_pkg::*;
#(
	parameter int NUM_GRIDS = DEF_NUM_GRIDS,
	parameter int MAX_ROWS  = DEF_MAX_ROWS,
	parameter int MAX_COLS  = DEF_MAX_COLS
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  in_item_t  in_item,
	output logic      out_valid,
	input  logic      out_ready,
	output out_item_t out_item
);
	logic cmd_valid, cmd_ready;
	cmd_t cmd;

	tgsb_front #(.NUM_GRIDS(NUM_GRIDS), .MAX_ROWS(MAX_ROWS), .MAX_COLS(MAX_COLS)) u_front (
		.clk, .arst_n, .in_valid, .in_ready, .in_item, .cmd_valid, .cmd_ready, .cmd
	);

	tgsb_back #(.NUM_GRIDS(NUM_GRIDS), .MAX_ROWS(MAX_ROWS), .MAX_COLS(MAX_COLS)) u_back (
		.clk, .arst_n, .cmd_valid, .cmd_ready, .cmd, .out_valid, .out_ready, .out_item
	);

	a_cmd_hold: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && !cmd_ready |=> cmd_valid)
		else $error("command dropped while stalled");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_item))
		else $error("result changed while stalled");

	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_item.status != 2'd3)
		else $error("bad status");
endmodule

/* verif/text_grid_screen_buffer_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_grid_screen_buffer_test: self-checking bench for the grid buffer
// Drives line runs, resizes, clears, scrolls, cursor moves, destroys and cell
// reads with random idling on both sides, and checks every result item
// against a behavioral copy of the grid store kept in the bench.
// ----------------------------------------------------------------------------
module text_grid_screen_buffer_test;
	import tgsb_pkg::*;

	localparam int NG = DEF_NUM_GRIDS;
	localparam int NR = DEF_MAX_ROWS;
	localparam int NC = DEF_MAX_COLS;

	class grid_scoreboard;
		logic [CELL_W-1:0] cells [int];
		bit                present [NG];
		int                wid [NG];
		int                hgt [NG];
		int                cur_r [NG];
		int                cur_c [NG];
		int                cur_grid;
		bit                line_open;
		int                line_grid, line_row, line_col;
		logic [15:0]       line_hl;
		out_item_t         pending [$];
		int                errors;

		function int addr(int g, int r, int c);
			return (g * NR + r) * NC + c;
		endfunction

		function logic [CELL_W-1:0] peek(int g, int r, int c);
			if (cells.exists(addr(g, r, c)))
				return cells[addr(g, r, c)];
			return '0;
		endfunction

		function int clampv(int v, int lo, int hi);
			return v < lo ? lo : (v > hi ? hi : v);
		endfunction

		function void make_grid(int g);
			if (!present[g]) begin
				present[g] = 1;
				wid[g] = 0;
				hgt[g] = 0;
			end
		endfunction

		function logic [1:0] line_run(in_item_t it);
			int n;
			int rep;
			logic [CELL_W-1:0] cv;
			if (it.run_start) begin
				line_open = 0;
				if (!present[it.grid_id])
					return ST_ABSENT;
				if (it.row_or_top < 0 || it.row_or_top >= hgt[it.grid_id] ||
						it.col_or_left < 0)
					return ST_REJECT;
				line_open = 1;
				line_grid = int'(it.grid_id);
				line_row = int'(it.row_or_top);
				line_col = int'(it.col_or_left);
				line_hl = '0;
			end else begin
				if (!line_open)
					return ST_REJECT;
				if (!present[line_grid]) begin
					line_open = 0;
					return ST_ABSENT;
				end
				if (line_row >= hgt[line_grid]) begin
					line_open = 0;
					return ST_REJECT;
				end
			end
			if (it.highlight_given)
				line_hl = it.highlight;
			rep = int'(it.count);
			cv = {line_hl, it.glyph};
			for (n = 0; n < rep && line_col < wid[line_grid]; n++) begin
				cells[addr(line_grid, line_row, line_col)] = cv;
				line_col++;
			end
			return ST_OK;
		endfunction

		function void note_item(in_item_t it);
			out_item_t o;
			int g, r, c, w, h, t, b, l, rt, k;
			g = int'(it.grid_id);
			o = '0;
			o.status = ST_OK;
			case (it.mode)
			MODE_LINE: o.status = line_run(it);
			MODE_RESIZE: begin
				make_grid(g);
				w = clampv(it.col_or_left, 0, NC);
				h = clampv(it.row_or_top, 0, NR);
				for (r = 0; r < h; r++)
					for (c = 0; c < w; c++)
						if (!(r < hgt[g] && c < wid[g]))
							cells[addr(g, r, c)] = CELL_W'(BLANK_GLYPH);
				wid[g] = w;
				hgt[g] = h;
			end
			MODE_CLEAR: begin
				if (!present[g])
					o.status = ST_ABSENT;
				else
					for (r = 0; r < hgt[g]; r++)
						for (c = 0; c < wid[g]; c++)
							cells[addr(g, r, c)] = CELL_W'(BLANK_GLYPH);
			end
			MODE_SCROLL: begin
				if (!present[g])
					o.status = ST_ABSENT;
				else begin
					t = clampv(it.row_or_top, 0, hgt[g]);
					b = clampv(it.bottom, 0, hgt[g]);
					l = clampv(it.col_or_left, 0, wid[g]);
					rt = clampv(it.right, 0, wid[g]);
					k = int'(it.count);
					if (k > 0) begin
						for (r = t; r + k < b; r++)
							for (c = l; c < rt; c++)
								cells[addr(g, r, c)] = peek(g, r + k, c);
					end else if (k < 0) begin
						for (r = b - 1; r + k >= t; r--)
							for (c = l; c < rt; c++)
								cells[addr(g, r, c)] = peek(g, r + k, c);
					end
				end
			end
			MODE_CURSOR: begin
				make_grid(g);
				cur_grid = g;
				cur_r[g] = int'(it.row_or_top);
				cur_c[g] = int'(it.col_or_left);
			end
			MODE_DESTROY: begin
				if (!present[g])
					o.status = ST_ABSENT;
				else begin
					present[g] = 0;
					wid[g] = 0;
					hgt[g] = 0;
					cur_r[g] = 0;
					cur_c[g] = 0;
					if (line_grid == g)
						line_open = 0;
				end
			end
			MODE_READ: begin
				r = int'(it.row_or_top);
				c = int'(it.col_or_left);
				if (!present[g])
					o.status = ST_ABSENT;
				else if (r < 0 || r >= hgt[g] || c < 0 || c >= wid[g])
					o.status = ST_REJECT;
				else
					{o.cell_highlight, o.cell_glyph} = peek(g, r, c);
			end
			default: ;
			endcase
			o.cursor_slot = 3'(cur_grid);
			if (present[cur_grid]) begin
				o.cursor_row_out = 16'(cur_r[cur_grid]);
				o.cursor_col_out = 16'(cur_c[cur_grid]);
			end
			pending.push_back(o);
		endfunction

		function void check_result(out_item_t got);
			out_item_t e;
			if (pending.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected result %p", got);
				return;
			end
			e = pending.pop_front();
			if (got !== e) begin
				errors++;
				if (errors <= 10)
					$display("mismatch: expected %p got %p", e, got);
			end
		endfunction
	endclass

	logic      clk;
	logic      arst_n;
	logic      in_valid;
	logic      in_ready;
	in_item_t  in_item;
	logic      out_valid;
	logic      out_ready;
	out_item_t out_item;

	grid_scoreboard board;
	int  cycles;
	int  recv_wait;
	int  n_out;
	int  n_out_seen;
	bit  grid_sized [NG];

	text_grid_screen_buffer dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
		.out_valid(out_valid), .out_ready(out_ready), .out_item(out_item)
	);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// sample at the rising edge, decide stall at the falling one
	always @(posedge clk) begin
		cycles++;
		if (arst_n && out_valid && out_ready) begin
			board.check_result(out_item);
			n_out++;
		end
		if (arst_n && in_valid && in_ready)
			board.note_item(in_item);
	end

	// draw a new wait after every accepted result
	always @(negedge clk) begin
		if (!arst_n) begin
			out_ready <= 0;
			recv_wait = $urandom_range(0, 17);
		end else if (n_out != n_out_seen) begin
			n_out_seen = n_out;
			recv_wait = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17);
			out_ready <= (recv_wait == 0);
		end else if (recv_wait > 0) begin
			recv_wait--;
			out_ready <= (recv_wait == 0);
		end else
			out_ready <= 1;
	end

	always @(posedge clk)
		if (cycles > 200000000) begin
			$display("[text_grid_screen_buffer] ERROR");
			$finish;
		end

	// returns at the accepting edge; the next call drops or replaces the item
	task automatic send_item(in_item_t it, int gap);
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1;
		in_item <= it;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	function automatic in_item_t base_item(logic [2:0] m, int g);
		in_item_t it;
		it = '0;
		it.mode = m;
		it.grid_id = 3'(g);
		return it;
	endfunction

	function automatic logic [15:0] pick_pos(int lim);
		case ($urandom_range(0, 9))
		0: return 16'($urandom);
		1: return -16'($urandom_range(1, 3));
		2: return 16'(lim + $urandom_range(0, 3));
		default: return 16'($urandom_range(0, lim > 0 ? lim - 1 : 0));
		endcase
	endfunction

	// reads only where every cell was written: the grid must have a size history
	function automatic in_item_t random_item();
		in_item_t it;
		int g, sel;
		int h, w;
		g = $urandom_range(0, NG - 1);
		sel = $urandom_range(0, 99);
		h = board.hgt[g];
		w = board.wid[g];
		it = '0;
		it.grid_id = 3'(g);
		it.glyph = 21'($urandom);
		it.highlight = 16'($urandom);
		it.highlight_given = 1'($urandom);
		it.bottom = 16'($urandom);
		it.right = 16'($urandom);
		if (sel < 6) begin
			it.mode = MODE_RESIZE;
			it.row_or_top = ($urandom_range(0, 9) == 0) ? 16'($urandom)
				: 16'($urandom_range(0, 12));
			it.col_or_left = ($urandom_range(0, 9) == 0) ? 16'($urandom)
				: 16'($urandom_range(0, 20));
			if ($urandom_range(0, 60) == 0) begin
				it.row_or_top = 16'sd32767;
				it.col_or_left = 16'sd32767;
			end
		end else if (sel < 8) begin
			it.mode = MODE_CLEAR;
		end else if (sel < 14) begin
			it.mode = MODE_SCROLL;
			it.row_or_top = pick_pos(h);
			it.bottom = pick_pos(h + 1);
			it.col_or_left = pick_pos(w);
			it.right = pick_pos(w + 1);
			it.count = ($urandom_range(0, 15) == 0) ? 16'($urandom)
				: 16'($signed($urandom_range(0, 10)) - 5);
		end else if (sel < 18) begin
			it.mode = MODE_CURSOR;
			it.row_or_top = 16'($urandom);
			it.col_or_left = 16'($urandom);
		end else if (sel < 20) begin
			it.mode = MODE_DESTROY;
		end else if (sel < 50) begin
			it.mode = MODE_READ;
			it.row_or_top = pick_pos(h);
			it.col_or_left = pick_pos(w);
		end else if (sel < 98) begin
			it.mode = MODE_LINE;
			it.run_start = ($urandom_range(0, 2) == 0);
			it.row_or_top = pick_pos(h);
			it.col_or_left = pick_pos(w);
			it.count = ($urandom_range(0, 15) == 0) ? 16'($urandom)
				: 16'($signed($urandom_range(0, 8)) - 1);
		end else
			it.mode = 3'd7;
		// hold off reads where a grid came to life without sizing
		if (it.mode == MODE_READ && board.present[g] && !grid_sized[g])
			it.mode = MODE_CURSOR;
		return it;
	endfunction

	task automatic drive(in_item_t it);
		if (it.mode == MODE_RESIZE)
			grid_sized[it.grid_id] = 1;
		send_item(it, ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(0, 17));
	endtask

	// drop the input and hold off until every expected result has come
	task automatic drain();
		@(negedge clk);
		in_valid <= 0;
		while (board.pending.size() > 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	initial begin
		in_item_t it;
		board = new();
		cycles = 0;
		n_out = 0;
		n_out_seen = 0;
		arst_n = 0;
		in_valid = 0;
		in_item = '0;
		out_ready = 0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// directed: absent grids, creation, extremes, each mode
		drive(base_item(MODE_READ, 2));
		drive(base_item(MODE_CLEAR, 2));
		drive(base_item(MODE_SCROLL, 2));
		drive(base_item(MODE_DESTROY, 2));
		it = base_item(MODE_LINE, 2);
		it.run_start = 1;
		drive(it);
		drive(base_item(MODE_LINE, 2));
		it = base_item(MODE_RESIZE, 7);
		it.row_or_top = 16'sh7fff;
		it.col_or_left = 16'sh7fff;
		drive(it);
		it = base_item(MODE_LINE, 7);
		it.run_start = 1;
		it.row_or_top = 16'(NR - 1);
		it.col_or_left = 16'(NC - 3);
		it.count = 16'sh7fff;
		it.glyph = '1;
		it.highlight = '1;
		it.highlight_given = 1;
		drive(it);
		it.run_start = 0;
		it.glyph = 0;
		drive(it);
		it = base_item(MODE_READ, 7);
		it.row_or_top = 16'(NR - 1);
		it.col_or_left = 16'(NC - 1);
		drive(it);
		it = base_item(MODE_SCROLL, 7);
		it.row_or_top = 16'sh8000;
		it.bottom = 16'sh7fff;
		it.col_or_left = 16'(NC - 4);
		it.right = 16'sh7fff;
		it.count = 16'sh8000;
		drive(it);
		it.count = 1;
		drive(it);
		it = base_item(MODE_RESIZE, 7);
		it.row_or_top = 16'sh8000;
		it.col_or_left = 16'sh8000;
		drive(it);
		it = base_item(MODE_CURSOR, 3);
		it.row_or_top = 16'sh8000;
		it.col_or_left = 16'sh7fff;
		drive(it);
		grid_sized[3] = 1;
		drive(base_item(3'd7, 3));
		drive(base_item(MODE_CLEAR, 3));
		drive(base_item(MODE_DESTROY, 3));
		it = base_item(MODE_READ, 7);
		it.row_or_top = -16'sd1;
		drive(it);
		drain();

		for (int i = 0; i < 1400; i++) begin
			it = random_item();
			drive(it);
			if (i == 700)
				drain();
		end
		drain();
		if (board.errors == 0 && board.pending.size() == 0)
			$display("[text_grid_screen_buffer] OK");
		else
			$display("[text_grid_screen_buffer] ERROR");
		$finish;
	end
endmodule
